FILE: rtl/core/dsa_pkg.sv
// shared types, constants and arithmetic helpers for decimal scale alignment
`default_nettype none
package dsa_pkg;

  localparam int MAX_SCALE_DEF  = 28;
  localparam int MANT_BITS_DEF  = 96;
  localparam int MANT_W         = 96;
  localparam int WORD_W         = 192;
  localparam int CNT_W          = 5;
  localparam int LIMB_W         = 32;
  localparam int DIV_LIMBS      = 3;
  // 10^29 exceeds 2^96, so more cut steps than this always give zero
  localparam int DIV_STEPS      = 28;
  localparam int DIV_STAGES     = DIV_STEPS * DIV_LIMBS;
  localparam int QDEPTH         = 2;
  // ceil(2^39 / 10), exact for numerators below 2^36
  localparam logic [35:0] DIV10_RECIP = 36'hCCCCCCCCD;

  typedef struct packed {
    logic [MANT_W-1:0] ma;
    logic [MANT_W-1:0] mb;
    logic [CNT_W-1:0]  ka;
    logic [CNT_W-1:0]  kb;
    logic [CNT_W-1:0]  ca;
    logic [CNT_W-1:0]  cb;
    logic [CNT_W-1:0]  scale;
    logic              sa;
    logic              sb;
  } item_t;

  typedef struct packed {
    item_t      it;
    logic [3:0] ra;
    logic [3:0] rb;
  } div_t;

  typedef struct packed {
    logic [WORD_W-1:0] wa;
    logic [WORD_W-1:0] wb;
    logic [CNT_W-1:0]  ca;
    logic [CNT_W-1:0]  cb;
    logic [CNT_W-1:0]  scale;
    logic              sa;
    logic              sb;
  } mul_t;

  // {remainder:limb} / 10, returns {quotient, remainder}
  function automatic logic [35:0] div10_limb(input logic [3:0] rem, input logic [31:0] limb);
    logic [35:0] v;
    logic [71:0] p;
    logic [31:0] q;
    logic [35:0] qx10;
    v    = {rem, limb};
    p    = 72'(v) * 72'(DIV10_RECIP);
    q    = p[70:39];
    qx10 = ({4'd0, q} << 3) + ({4'd0, q} << 1);
    div10_limb = {q, 4'(v - qx10)};
  endfunction

  // one limb of one divide-by-ten step, high limb first
  function automatic div_t div_stage(input div_t p, input int step, input int limb);
    div_t        o;
    logic [35:0] qa;
    logic [35:0] qb;
    logic [3:0]  ria;
    logic [3:0]  rib;
    o   = p;
    ria = (limb == DIV_LIMBS - 1) ? 4'd0 : p.ra;
    rib = (limb == DIV_LIMBS - 1) ? 4'd0 : p.rb;
    qa  = div10_limb(ria, p.it.ma[limb*LIMB_W +: LIMB_W]);
    qb  = div10_limb(rib, p.it.mb[limb*LIMB_W +: LIMB_W]);
    if (p.it.ka > CNT_W'(step)) begin
      o.it.ma[limb*LIMB_W +: LIMB_W] = qa[35:4];
      o.ra = qa[3:0];
    end
    if (p.it.kb > CNT_W'(step)) begin
      o.it.mb[limb*LIMB_W +: LIMB_W] = qb[35:4];
      o.rb = qb[3:0];
    end
    div_stage = o;
  endfunction

  function automatic logic [WORD_W-1:0] times10(input logic [WORD_W-1:0] x);
    times10 = (x << 3) + (x << 1);
  endfunction

  function automatic mul_t mul_stage(input mul_t p, input int step);
    mul_t o;
    o = p;
    if (p.ca > CNT_W'(step)) o.wa = times10(p.wa);
    if (p.cb > CNT_W'(step)) o.wb = times10(p.wb);
    mul_stage = o;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/dsa_fifo.sv
// small generic word queue with flop storage
`default_nettype none
module dsa_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = dsa_pkg::QDEPTH
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] din,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      dout,
  output logic              empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          push_ok, pop_ok;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_ok && !pop_ok) cnt_nxt = cnt_r + 1'b1;
    else if (pop_ok && !push_ok) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) mem_r[wr_ptr_r] <= din;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH)) else $error("queue count above depth");
  a_cnt_up: assert property (@(posedge clk) disable iff (!rst_n)
    push_ok && !pop_ok |=> cnt_r == $past(cnt_r) + 1'b1) else $error("push lost");
  a_cnt_down: assert property (@(posedge clk) disable iff (!rst_n)
    pop_ok && !push_ok |=> cnt_r == $past(cnt_r) - 1'b1) else $error("pop lost");

endmodule
`default_nettype wire

FILE: rtl/core/dsa_front.sv
// front end: masks mantissas, clamps scales and works out step counts
`default_nettype none
module dsa_front #(
  parameter int MAX_SCALE     = dsa_pkg::MAX_SCALE_DEF,
  parameter int MANTISSA_BITS = dsa_pkg::MANT_BITS_DEF
) (
  input  wire logic [63:0] a_mantissa_low,
  input  wire logic [31:0] a_mantissa_high,
  input  wire logic [7:0]  a_scale,
  input  wire logic        a_negative,
  input  wire logic [63:0] b_mantissa_low,
  input  wire logic [31:0] b_mantissa_high,
  input  wire logic [7:0]  b_scale,
  input  wire logic        b_negative,
  output dsa_pkg::item_t   item
);
  localparam logic [dsa_pkg::MANT_W-1:0] MANT_MASK =
    {dsa_pkg::MANT_W{1'b1}} >> (dsa_pkg::MANT_W - MANTISSA_BITS);

  logic [7:0]                ka_full, kb_full;
  logic                      zero_a, zero_b;
  logic [dsa_pkg::CNT_W-1:0] sa_c, sb_c, common;

  always_comb begin
    ka_full = (a_scale > 8'(MAX_SCALE)) ? a_scale - 8'(MAX_SCALE) : 8'd0;
    kb_full = (b_scale > 8'(MAX_SCALE)) ? b_scale - 8'(MAX_SCALE) : 8'd0;
    // a cut this long always leaves zero
    zero_a  = ka_full > 8'(dsa_pkg::DIV_STEPS);
    zero_b  = kb_full > 8'(dsa_pkg::DIV_STEPS);
    sa_c    = (a_scale > 8'(MAX_SCALE)) ? dsa_pkg::CNT_W'(MAX_SCALE) : a_scale[4:0];
    sb_c    = (b_scale > 8'(MAX_SCALE)) ? dsa_pkg::CNT_W'(MAX_SCALE) : b_scale[4:0];
    common  = (sa_c > sb_c) ? sa_c : sb_c;

    item.ma    = zero_a ? '0 : ({a_mantissa_high, a_mantissa_low} & MANT_MASK);
    item.mb    = zero_b ? '0 : ({b_mantissa_high, b_mantissa_low} & MANT_MASK);
    item.ka    = zero_a ? '0 : ka_full[4:0];
    item.kb    = zero_b ? '0 : kb_full[4:0];
    item.ca    = common - sa_c;
    item.cb    = common - sb_c;
    item.scale = common;
    item.sa    = a_negative;
    item.sb    = b_negative;
  end

endmodule
`default_nettype wire

FILE: rtl/core/dsa_div.sv
// divide-by-ten pipeline, one 32-bit limb of one step per stage
`default_nettype none
module dsa_div (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     adv,
  input  wire logic     in_valid,
  input  dsa_pkg::item_t in_item,
  output logic          out_valid,
  output dsa_pkg::item_t out_item
);
  localparam int NT = dsa_pkg::DIV_STAGES;

  dsa_pkg::div_t d_r   [NT];
  dsa_pkg::div_t d_prv [NT];
  dsa_pkg::div_t d_nxt [NT];
  logic [NT-1:0] vld_r;
  logic [NT:0]   vld_nxt;

  genvar t;
  generate
    for (t = 0; t < NT; t++) begin : g_stg
      if (t == 0) begin : g_head
        assign d_prv[t] = '{it: in_item, ra: 4'd0, rb: 4'd0};
      end else begin : g_body
        assign d_prv[t] = d_r[t-1];
      end
      assign d_nxt[t] = dsa_pkg::div_stage(d_prv[t], t / dsa_pkg::DIV_LIMBS,
                                           dsa_pkg::DIV_LIMBS - 1 - (t % dsa_pkg::DIV_LIMBS));
    end
  endgenerate

  assign vld_nxt = {vld_r, in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= vld_nxt[NT-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NT; i++) d_r[i] <= d_nxt[i];
    end
  end

  assign out_valid = vld_r[NT-1];
  assign out_item  = d_r[NT-1].it;

endmodule
`default_nettype wire

FILE: rtl/core/dsa_mul.sv
// multiply-by-ten pipeline, one step per stage on the smaller-scale operand
`default_nettype none
module dsa_mul #(
  parameter int MAX_SCALE = dsa_pkg::MAX_SCALE_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      adv,
  input  wire logic      in_valid,
  input  dsa_pkg::item_t in_item,
  output logic           out_valid,
  output dsa_pkg::mul_t  out_res
);
  localparam int NM = MAX_SCALE;

  dsa_pkg::mul_t m_r   [NM];
  dsa_pkg::mul_t m_prv [NM];
  dsa_pkg::mul_t m_nxt [NM];
  dsa_pkg::mul_t head;
  logic [NM-1:0] vld_r;
  logic [NM:0]   vld_nxt;

  always_comb begin
    head.wa    = dsa_pkg::WORD_W'(in_item.ma);
    head.wb    = dsa_pkg::WORD_W'(in_item.mb);
    head.ca    = in_item.ca;
    head.cb    = in_item.cb;
    head.scale = in_item.scale;
    head.sa    = in_item.sa;
    head.sb    = in_item.sb;
  end

  genvar t;
  generate
    for (t = 0; t < NM; t++) begin : g_stg
      if (t == 0) begin : g_head
        assign m_prv[t] = head;
      end else begin : g_body
        assign m_prv[t] = m_r[t-1];
      end
      assign m_nxt[t] = dsa_pkg::mul_stage(m_prv[t], t);
    end
  endgenerate

  assign vld_nxt = {vld_r, in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= vld_nxt[NM-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NM; i++) m_r[i] <= m_nxt[i];
    end
  end

  assign out_valid = vld_r[NM-1];
  assign out_res   = m_r[NM-1];

endmodule
`default_nettype wire

FILE: rtl/core/decimal_scale_alignment.sv
// top level: aligns two decimal operands to one common scale
//
// channel | direction | handshake           | words
// in_     | input     | in_push / in_full   | two mantissas, scales, signs
// out_    | output    | out_pop / out_empty | two 190-bit mantissas, scale, signs
//
// one word per cycle sustained while the output queue has room; each word passes
// through the input queue, the divide pipeline (one limb per stage) and the
// multiply pipeline (one step per stage) to the output queue
// reset is synchronous and only clears queue pointers, queue counts and stage valid bits
// the back pipeline stalls as a whole while the output queue is full; the
// input queue then absorbs up to two words before in_full rises
`default_nettype none
module decimal_scale_alignment #(
  parameter int MAX_SCALE     = dsa_pkg::MAX_SCALE_DEF,
  parameter int MANTISSA_BITS = dsa_pkg::MANT_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [63:0] in_a_mantissa_low,
  input  wire logic [31:0] in_a_mantissa_high,
  input  wire logic [7:0]  in_a_scale,
  input  wire logic        in_a_negative,
  input  wire logic [63:0] in_b_mantissa_low,
  input  wire logic [31:0] in_b_mantissa_high,
  input  wire logic [7:0]  in_b_scale,
  input  wire logic        in_b_negative,
  input  wire logic        out_pop,
  output logic             out_empty,
  output logic [63:0]      out_a_word0,
  output logic [63:0]      out_a_word1,
  output logic [61:0]      out_a_word2,
  output logic [63:0]      out_b_word0,
  output logic [63:0]      out_b_word1,
  output logic [61:0]      out_b_word2,
  output logic [4:0]       out_common_scale,
  output logic             out_a_sign_out,
  output logic             out_b_sign_out
);
  localparam int IW = $bits(dsa_pkg::item_t);
  localparam int RW = $bits(dsa_pkg::mul_t);

  dsa_pkg::item_t fr_item, mq_item, dv_item;
  dsa_pkg::mul_t  ml_res, oq_res;
  logic [IW-1:0]  mq_din, mq_dout;
  logic [RW-1:0]  oq_din, oq_dout;
  logic           mq_empty, oq_full;
  logic           dv_valid, ml_valid;
  logic           adv;

  dsa_front #(.MAX_SCALE(MAX_SCALE), .MANTISSA_BITS(MANTISSA_BITS)) u_front (
    .a_mantissa_low (in_a_mantissa_low),
    .a_mantissa_high(in_a_mantissa_high),
    .a_scale        (in_a_scale),
    .a_negative     (in_a_negative),
    .b_mantissa_low (in_b_mantissa_low),
    .b_mantissa_high(in_b_mantissa_high),
    .b_scale        (in_b_scale),
    .b_negative     (in_b_negative),
    .item           (fr_item)
  );

  assign mq_din  = fr_item;
  assign mq_item = mq_dout;

  dsa_fifo #(.W(IW), .DEPTH(dsa_pkg::QDEPTH)) u_midq (
    .clk  (clk),
    .rst_n(rst_n),
    .push (in_push),
    .din  (mq_din),
    .full (in_full),
    .pop  (adv),
    .dout (mq_dout),
    .empty(mq_empty)
  );

  // whole back pipeline moves only when the output queue has room
  assign adv = !oq_full;

  dsa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (!mq_empty),
    .in_item  (mq_item),
    .out_valid(dv_valid),
    .out_item (dv_item)
  );

  dsa_mul #(.MAX_SCALE(MAX_SCALE)) u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (dv_valid),
    .in_item  (dv_item),
    .out_valid(ml_valid),
    .out_res  (ml_res)
  );

  assign oq_din = ml_res;
  assign oq_res = oq_dout;

  dsa_fifo #(.W(RW), .DEPTH(dsa_pkg::QDEPTH)) u_outq (
    .clk  (clk),
    .rst_n(rst_n),
    .push (ml_valid && adv),
    .din  (oq_din),
    .full (oq_full),
    .pop  (out_pop),
    .dout (oq_dout),
    .empty(out_empty)
  );

  assign out_a_word0      = oq_res.wa[63:0];
  assign out_a_word1      = oq_res.wa[127:64];
  assign out_a_word2      = oq_res.wa[189:128];
  assign out_b_word0      = oq_res.wb[63:0];
  assign out_b_word1      = oq_res.wb[127:64];
  assign out_b_word2      = oq_res.wb[189:128];
  assign out_common_scale = oq_res.scale;
  assign out_a_sign_out   = oq_res.sa;
  assign out_b_sign_out   = oq_res.sb;

endmodule
`default_nettype wire
